>>> design/csme_pkg.sv
package csme_pkg;

  // Operation codes on the input channel
  localparam logic [1:0] OP_CW    = 2'd0;
  localparam logic [1:0] OP_CCW   = 2'd1;
  localparam logic [1:0] OP_PRESS = 2'd2;

  // Field selection codes
  localparam logic [2:0] SEL_YEAR   = 3'd0;
  localparam logic [2:0] SEL_MONTH  = 3'd1;
  localparam logic [2:0] SEL_DAY    = 3'd2;
  localparam logic [2:0] SEL_HOUR   = 3'd3;
  localparam logic [2:0] SEL_MINUTE = 3'd4;
  localparam logic [2:0] SEL_SECOND = 3'd5;

  localparam logic [7:0] YEAR_MAX        = 8'd99;
  localparam logic [7:0] MONTH_MIN       = 8'd1;
  localparam logic [7:0] MONTH_MAX       = 8'd12;
  localparam logic [7:0] DAY_MIN         = 8'd1;
  localparam logic [7:0] HOUR_MAX        = 8'd23;
  localparam logic [7:0] MINSEC_MAX      = 8'd59;
  localparam logic [2:0] WEEKDAY_DEFAULT = 3'd1;

  localparam int CSME_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_CW,
    CMD_CCW,
    CMD_PRESS
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       rtc_valid;
    logic [5:0] rtc_second;
    logic [5:0] rtc_minute;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_day;
    logic [4:0] rtc_month;
    logic [2:0] rtc_weekday;
    logic [7:0] rtc_year;
  } in_item_t;

  typedef struct packed {
    logic       in_set_mode;
    logic [2:0] selected_field;
    logic [5:0] out_second;
    logic [5:0] out_minute;
    logic [4:0] out_hour;
    logic [5:0] out_day;
    logic [4:0] out_month;
    logic [2:0] out_weekday;
    logic [7:0] out_year;
    logic       commit;
  } out_item_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [5:0] day;
    logic [4:0] month;
    logic [2:0] weekday;
    logic [7:0] year;
  } clk_reading_t;

  typedef struct packed {
    cmd_kind_t    kind;
    logic         rtc_valid;
    clk_reading_t reading;
  } cmd_t;

  // Days in month; out-of-range months use the nearest valid month's length
  function automatic logic [4:0] month_days(input logic [7:0] year, input logic [4:0] month);
    logic [4:0] d;
    begin
      if (month == 5'd0) begin
        d = 5'd31;
      end else if (month > 5'd12) begin
        d = 5'd31;
      end else begin
        case (month)
          5'd2:    d = 5'd28;
          5'd4:    d = 5'd30;
          5'd6:    d = 5'd30;
          5'd9:    d = 5'd30;
          5'd11:   d = 5'd30;
          default: d = 5'd31;
        endcase
      end
      if (month == 5'd2 && year[1:0] == 2'b00) begin
        d = 5'd29;
      end
      return d;
    end
  endfunction

  // Step v by one over lo..hi, wrapping with the editor's tests
  function automatic logic [7:0] wrap_step(input logic [7:0] v, input logic up,
                                           input logic [7:0] lo, input logic [7:0] hi);
    logic [8:0] s;
    logic [7:0] r;
    begin
      s = 9'd0;
      if (up) begin
        s = {1'b0, v} + 9'd1;
        r = (s > {1'b0, hi}) ? lo : s[7:0];
      end else if (v <= lo) begin
        r = hi;
      end else begin
        r = v - 8'd1;
        if (r > hi) begin
          r = lo;
        end
      end
      return r;
    end
  endfunction

  function automatic logic [5:0] clamp_day(input logic [5:0] day, input logic [4:0] dim);
    logic [5:0] r;
    begin
      r = day;
      if (r == 6'd0) begin
        r = 6'(DAY_MIN);
      end
      if (r > {1'b0, dim}) begin
        r = {1'b0, dim};
      end
      return r;
    end
  endfunction

endpackage

>>> design/csme_front.sv
module csme_front
  import csme_pkg::*;
(
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_push_data
);

  cmd_kind_t kind;

  always_comb begin
    case (in_data.operation)
      OP_CW:    kind = CMD_CW;
      OP_CCW:   kind = CMD_CCW;
      OP_PRESS: kind = CMD_PRESS;
      default:  kind = CMD_NOP;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_push_data.kind            = kind;
    q_push_data.rtc_valid       = in_data.rtc_valid;
    q_push_data.reading.second  = in_data.rtc_second;
    q_push_data.reading.minute  = in_data.rtc_minute;
    q_push_data.reading.hour    = in_data.rtc_hour;
    q_push_data.reading.day     = in_data.rtc_day;
    q_push_data.reading.month   = in_data.rtc_month;
    q_push_data.reading.weekday = in_data.rtc_weekday;
    q_push_data.reading.year    = in_data.rtc_year;
  end

endmodule

>>> design/csme_queue.sv
module csme_queue
  import csme_pkg::*;
#(
  parameter int DEPTH = CSME_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/csme_back.sv
module csme_back
  import csme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  cmd_t      q_pop_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic         set_mode_r, set_mode_nxt;
  logic [2:0]   field_r, field_nxt;
  clk_reading_t edit_r, edit_nxt;
  logic         commit;
  logic         up;
  logic         fire;
  logic [7:0]   year_new;
  logic [7:0]   month_new;
  logic [7:0]   step_val;
  logic         out_valid_r;
  out_item_t    out_data_r;

  assign fire      = q_not_empty && (!out_valid_r || out_ready);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign up        = (q_pop_data.kind == CMD_CW);

  always_comb begin
    set_mode_nxt = set_mode_r;
    field_nxt    = field_r;
    edit_nxt     = edit_r;
    commit       = 1'b0;
    year_new     = '0;
    month_new    = '0;
    step_val     = '0;
    case (q_pop_data.kind)
      CMD_PRESS: begin
        if (!set_mode_r) begin
          if (q_pop_data.rtc_valid) begin
            edit_nxt     = q_pop_data.reading;
            set_mode_nxt = 1'b1;
            field_nxt    = SEL_YEAR;
          end
        end else if (field_r == SEL_SECOND) begin
          if (edit_r.weekday == 3'd0) begin
            edit_nxt.weekday = WEEKDAY_DEFAULT;
          end
          commit       = 1'b1;
          set_mode_nxt = 1'b0;
        end else if (field_r < SEL_SECOND) begin
          field_nxt = field_r + 3'd1;
        end else begin
          field_nxt = SEL_YEAR;
        end
      end
      CMD_CW, CMD_CCW: begin
        if (set_mode_r) begin
          case (field_r)
            SEL_YEAR: begin
              if (up) begin
                year_new = (edit_r.year >= YEAR_MAX) ? YEAR_MAX : edit_r.year + 8'd1;
              end else begin
                year_new = (edit_r.year == 8'd0) ? 8'd0 : edit_r.year - 8'd1;
                if (year_new > YEAR_MAX) begin
                  year_new = YEAR_MAX;
                end
              end
              edit_nxt.year = year_new;
              edit_nxt.day  = clamp_day(edit_r.day, month_days(year_new, edit_r.month));
            end
            SEL_MONTH: begin
              month_new      = wrap_step({3'b0, edit_r.month}, up, MONTH_MIN, MONTH_MAX);
              edit_nxt.month = month_new[4:0];
              edit_nxt.day   = clamp_day(edit_r.day, month_days(edit_r.year, month_new[4:0]));
            end
            SEL_DAY: begin
              step_val     = wrap_step({2'b0, edit_r.day}, up, DAY_MIN,
                                       {3'b0, month_days(edit_r.year, edit_r.month)});
              edit_nxt.day = step_val[5:0];
            end
            SEL_HOUR: begin
              step_val      = wrap_step({3'b0, edit_r.hour}, up, 8'd0, HOUR_MAX);
              edit_nxt.hour = step_val[4:0];
            end
            SEL_MINUTE: begin
              step_val        = wrap_step({2'b0, edit_r.minute}, up, 8'd0, MINSEC_MAX);
              edit_nxt.minute = step_val[5:0];
            end
            SEL_SECOND: begin
              step_val        = wrap_step({2'b0, edit_r.second}, up, 8'd0, MINSEC_MAX);
              edit_nxt.second = step_val[5:0];
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_mode_r  <= 1'b0;
      field_r     <= SEL_HOUR;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        set_mode_r  <= set_mode_nxt;
        field_r     <= field_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Edit registers and result payload hold their value until the next transaction
  always_ff @(posedge clk) begin
    if (fire) begin
      edit_r                    <= edit_nxt;
      out_data_r.in_set_mode    <= set_mode_nxt;
      out_data_r.selected_field <= field_nxt;
      out_data_r.out_second     <= edit_nxt.second;
      out_data_r.out_minute     <= edit_nxt.minute;
      out_data_r.out_hour       <= edit_nxt.hour;
      out_data_r.out_day        <= edit_nxt.day;
      out_data_r.out_month      <= edit_nxt.month;
      out_data_r.out_weekday    <= edit_nxt.weekday;
      out_data_r.out_year       <= edit_nxt.year;
      out_data_r.commit         <= commit;
    end
  end

endmodule

>>> design/clock_set_mode_editor.sv
// Clock-setting editor driven by knob events.
// Input channel (in_valid/in_ready/in_data): one knob event per transaction,
// rotate clockwise, rotate counter-clockwise or button press, together with
// the current clock reading and its valid flag.
// Result channel (out_valid/out_ready/out_data): one result per event, giving
// the mode, the selected field, the edited time and a commit strobe that asks
// for the edited time to be written to the clock.
// Throughput: one event per cycle while the receiver is not stalling. An event
// that is taken is written into a queue entry; the editor stage then pops it and
// updates the edit registers and the output register from it.
// The front classifies events into a queue of QUEUE_DEPTH entries; the back
// drains it whenever the output register is free or being read.
// When the receiver stalls, the output register holds its result, the queue
// fills and in_ready drops once it is full.
// Reset (rst_n low at a clock edge): normal mode, hour selected, queue and
// output empty. Edit registers are loaded by the first valid entry press.
module clock_set_mode_editor
  import csme_pkg::*;
#(
  parameter int QUEUE_DEPTH = CSME_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic q_full;
  logic q_push;
  cmd_t q_push_data;
  logic q_pop;
  cmd_t q_pop_data;
  logic q_not_empty;

  csme_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  csme_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  csme_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_pop_data  (q_pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> tb/tb_clock_set_mode_editor.sv
`timescale 1ns / 1ps

module tb_clock_set_mode_editor;
  import csme_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LIVE_EVENT_TARGET = 1280;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_GAP = 12;

  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t want;
  } knob_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Mirror of the editor state
  logic       m_set_mode;
  logic [2:0] m_field;
  logic [5:0] m_sec;
  logic [5:0] m_min;
  logic [4:0] m_hour;
  logic [5:0] m_day;
  logic [4:0] m_month;
  logic [2:0] m_wday;
  logic [7:0] m_year;

  out_item_t want_views[$];
  knob_row_t knob_rows[$];

  int cycle_count;
  int mismatch_count = 0;
  int view_count = 0;
  int commit_count = 0;
  int refused_count = 0;
  int ignored_count = 0;
  int live_events = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  clock_set_mode_editor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int month_length(logic [7:0] yr, logic [4:0] mo);
    int len;
    case (mo)
      5'd2: len = (yr[1:0] == 2'b00) ? 29 : 28;
      5'd4, 5'd6, 5'd9, 5'd11: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  function automatic int wrap_by_one(int v, bit up, int lo, int hi);
    if (up) return (v + 1 > hi) ? lo : v + 1;
    if (v <= lo) return hi;
    return (v - 1 > hi) ? lo : v - 1;
  endfunction

  function automatic void fit_day();
    int dim;
    dim = month_length(m_year, m_month);
    if (int'(m_day) < int'(DAY_MIN)) m_day = 6'(DAY_MIN);
    if (int'(m_day) > dim) m_day = 6'(dim);
  endfunction

  function automatic void turn_knob(bit up);
    int y;
    case (m_field)
      SEL_YEAR: begin
        if (up) y = int'(m_year) + 1;
        else y = (m_year == 8'd0) ? 0 : int'(m_year) - 1;
        m_year = 8'((y > int'(YEAR_MAX)) ? int'(YEAR_MAX) : y);
        fit_day();
      end
      SEL_MONTH: begin
        m_month = 5'(wrap_by_one(int'(m_month), up, int'(MONTH_MIN), int'(MONTH_MAX)));
        fit_day();
      end
      SEL_DAY: m_day = 6'(wrap_by_one(int'(m_day), up, int'(DAY_MIN),
                                      month_length(m_year, m_month)));
      SEL_HOUR: m_hour = 5'(wrap_by_one(int'(m_hour), up, 0, int'(HOUR_MAX)));
      SEL_MINUTE: m_min = 6'(wrap_by_one(int'(m_min), up, 0, int'(MINSEC_MAX)));
      SEL_SECOND: m_sec = 6'(wrap_by_one(int'(m_sec), up, 0, int'(MINSEC_MAX)));
      default: ;
    endcase
  endfunction

  // Apply one knob event to the mirror and return the view it produces
  function automatic out_item_t edit_knob_event(in_item_t ev);
    out_item_t v;
    logic fire;
    fire = 1'b0;
    case (ev.operation)
      OP_PRESS: begin
        if (!m_set_mode) begin
          if (ev.rtc_valid) begin
            m_sec = ev.rtc_second;
            m_min = ev.rtc_minute;
            m_hour = ev.rtc_hour;
            m_day = ev.rtc_day;
            m_month = ev.rtc_month;
            m_wday = ev.rtc_weekday;
            m_year = ev.rtc_year;
            m_set_mode = 1'b1;
            m_field = SEL_YEAR;
          end
        end else if (m_field == SEL_SECOND) begin
          if (m_wday == 3'd0) m_wday = WEEKDAY_DEFAULT;
          fire = 1'b1;
          m_set_mode = 1'b0;
        end else if (m_field < SEL_SECOND) begin
          m_field = m_field + 3'd1;
        end else begin
          m_field = SEL_YEAR;
        end
      end
      OP_CW, OP_CCW: begin
        if (m_set_mode) turn_knob(ev.operation == OP_CW);
      end
      default: ;
    endcase
    v.in_set_mode = m_set_mode;
    v.selected_field = m_field;
    v.out_second = m_sec;
    v.out_minute = m_min;
    v.out_hour = m_hour;
    v.out_day = m_day;
    v.out_month = m_month;
    v.out_weekday = m_wday;
    v.out_year = m_year;
    v.commit = fire;
    return v;
  endfunction

  function automatic void add_row(in_item_t ev, bit typed, out_item_t want);
    knob_row_t r;
    r.ev = ev;
    r.typed = typed;
    r.want = want;
    knob_rows.push_back(r);
  endfunction

  function automatic int pick_value(int lo, int hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Mostly full editing sessions, with some noise and refused entries
  function automatic in_item_t rand_event();
    in_item_t ev;
    int pick;
    ev.rtc_valid = 1'($urandom_range(0, 1));
    ev.rtc_second = 6'(pick_value(0, 59));
    ev.rtc_minute = 6'(pick_value(0, 59));
    ev.rtc_hour = 5'(pick_value(0, 23));
    ev.rtc_day = 6'($urandom_range(0, 1) ? pick_value(1, 28) : pick_value(0, 45));
    ev.rtc_month = 5'($urandom_range(0, 1) ? pick_value(1, 12) : pick_value(0, 25));
    ev.rtc_weekday = 3'(pick_value(0, 7));
    ev.rtc_year = 8'($urandom_range(0, 1) ? pick_value(0, 99) : pick_value(0, 165));
    pick = $urandom_range(0, 99);
    if (m_set_mode) begin
      if (pick < 35) ev.operation = OP_CW;
      else if (pick < 70) ev.operation = OP_CCW;
      else if (pick < 96) ev.operation = OP_PRESS;
      else ev.operation = OP_UNUSED;
    end else begin
      if (pick < 70) begin
        ev.operation = OP_PRESS;
        ev.rtc_valid = 1'b1;
      end else if (pick < 82) ev.operation = OP_PRESS;
      else if (pick < 88) ev.operation = OP_CW;
      else if (pick < 94) ev.operation = OP_CCW;
      else ev.operation = OP_UNUSED;
    end
    return ev;
  endfunction

  task automatic send_event(in_item_t ev, bit typed, out_item_t want);
    int gap;
    out_item_t v;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    if (ev.operation == OP_UNUSED || (ev.operation != OP_PRESS && !m_set_mode)) begin
      ignored_count++;
    end else if (ev.operation == OP_PRESS && !m_set_mode && !ev.rtc_valid) begin
      ignored_count++;
      refused_count++;
    end else begin
      live_events++;
    end
    v = edit_knob_event(ev);
    want_views.push_back(typed ? want : v);
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: random stalls between transactions
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      view_count++;
      if (want_views.size() == 0) begin
        $error("result with no event pending");
        mismatch_count++;
      end else begin
        w = want_views.pop_front();
        if (w.commit) commit_count++;
        compare_field("in_set_mode", 8'(w.in_set_mode), 8'(out_data.in_set_mode));
        compare_field("selected_field", 8'(w.selected_field), 8'(out_data.selected_field));
        compare_field("out_second", 8'(w.out_second), 8'(out_data.out_second));
        compare_field("out_minute", 8'(w.out_minute), 8'(out_data.out_minute));
        compare_field("out_hour", 8'(w.out_hour), 8'(out_data.out_hour));
        compare_field("out_day", 8'(w.out_day), 8'(out_data.out_day));
        compare_field("out_month", 8'(w.out_month), 8'(out_data.out_month));
        compare_field("out_weekday", 8'(w.out_weekday), 8'(out_data.out_weekday));
        compare_field("out_year", w.out_year, out_data.out_year);
        compare_field("commit", 8'(w.commit), 8'(out_data.commit));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run timed out after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int n;
    m_set_mode = 1'b0;
    m_field = SEL_HOUR;
    {m_sec, m_min, m_hour, m_day, m_month, m_wday, m_year} = '0;

    // First entry at every upper limit but a zero weekday, then a full pass through the fields
    add_row({OP_PRESS, 1'b1, 6'd59, 6'd59, 5'd23, 6'd31, 5'd12, 3'd0, 8'd99}, 1'b1,
            {1'b1, SEL_YEAR, 6'd59, 6'd59, 5'd23, 6'd31, 5'd12, 3'd0, 8'd99, 1'b0});
    add_row({OP_CW, 40'd0}, 1'b1,
            {1'b1, SEL_YEAR, 6'd59, 6'd59, 5'd23, 6'd31, 5'd12, 3'd0, 8'd99, 1'b0});
    add_row({OP_PRESS, 40'd0}, 1'b1,
            {1'b1, SEL_MONTH, 6'd59, 6'd59, 5'd23, 6'd31, 5'd12, 3'd0, 8'd99, 1'b0});
    add_row({OP_CW, 40'd0}, 1'b0, '0);
    add_row({OP_PRESS, 40'd0}, 1'b0, '0);
    add_row({OP_CW, 40'd0}, 1'b0, '0);
    add_row({OP_PRESS, 40'd0}, 1'b0, '0);
    add_row({OP_CW, 40'd0}, 1'b0, '0);
    add_row({OP_PRESS, 40'd0}, 1'b0, '0);
    add_row({OP_CCW, 40'd0}, 1'b0, '0);
    add_row({OP_PRESS, 40'd0}, 1'b0, '0);
    add_row({OP_CW, 40'd0}, 1'b0, '0);
    // commit with a zero weekday, then events that must change nothing
    add_row({OP_PRESS, 40'd0}, 1'b0, '0);
    add_row({OP_CW, 40'd0}, 1'b0, '0);
    add_row({OP_PRESS, 1'b0, 6'd1, 6'd2, 5'd3, 6'd4, 5'd5, 3'd6, 8'd7}, 1'b0, '0);
    add_row({OP_UNUSED, 1'b1, 6'd1, 6'd2, 5'd3, 6'd4, 5'd5, 3'd6, 8'd7}, 1'b0, '0);
    // Out-of-range reading with year at its floor
    add_row({OP_PRESS, 1'b1, 6'd0, 6'd0, 5'd30, 6'd45, 5'd25, 3'd7, 8'd0}, 1'b1,
            {1'b1, SEL_YEAR, 6'd0, 6'd0, 5'd30, 6'd45, 5'd25, 3'd7, 8'd0, 1'b0});
    add_row({OP_CCW, 40'd0}, 1'b0, '0);
    add_row({OP_PRESS, 40'd0}, 1'b0, '0);
    add_row({OP_CCW, 40'd0}, 1'b0, '0);
    add_row({OP_PRESS, 40'd0}, 1'b0, '0);
    add_row({OP_CW, 40'd0}, 1'b0, '0);
    add_row({OP_PRESS, 40'd0}, 1'b0, '0);
    add_row({OP_CW, 40'd0}, 1'b0, '0);

    while (!rst_n) @(posedge clk);
    foreach (knob_rows[i]) send_event(knob_rows[i].ev, knob_rows[i].typed, knob_rows[i].want);

    n = 0;
    while (live_events < LIVE_EVENT_TARGET) begin
      if (n % 100 == 0) begin
        in_calm = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      if (n == 600) begin
        // hold off until the editor has caught up
        in_valid <= 1'b0;
        while (want_views.size() != 0) @(posedge clk);
      end
      send_event(rand_event(), 1'b0, '0);
      n++;
    end
    in_valid <= 1'b0;
    while (want_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d knob events (%0d without effect, %0d refused entries), checked %0d views.",
             live_events + ignored_count, ignored_count, refused_count, view_count);
    $display("Saw %0d commits with idle gaps and stalls of 0 to %0d cycles on both channels.",
             commit_count, MAX_GAP);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/csme_pkg.sv
design/csme_front.sv
design/csme_queue.sv
design/csme_back.sv
design/clock_set_mode_editor.sv
tb/tb_clock_set_mode_editor.sv
